FILE: sv/rgb_to_packed_pixels_with_mask_assert.svh
// assertion macros for the packed pixel converter
// needs i_clk and i_rst_n in the scope of the module that uses them
`ifndef RGB_TO_PACKED_PIXELS_WITH_MASK_ASSERT_SVH
`define RGB_TO_PACKED_PIXELS_WITH_MASK_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RTPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RTPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rtpp_pkg.sv
// shared types, constants and helpers of the packed pixel converter
// no dependencies
`default_nettype none

package rtpp_pkg;

    localparam int ROW_W         = 10;
    localparam int CFG_IDX_W     = 2;
    localparam int PIX_W         = 24;
    localparam int BYTE_W        = 8;
    localparam int BURST_N       = 4;
    localparam int CNT_W         = 3;
    localparam int ACC_W         = 16;
    localparam int SHIFT_W       = 4;
    localparam int MAX_WIDTH_DEF = 512;
    localparam int PAIR_MIN_WIDTH = 16;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RST = 10'd16;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WIDTH = 2'd0,
        CFG_TWO_BIT   = 2'd1,
        CFG_MASK_EN   = 2'd2
    } t_cfg_idx;

    // byte counts of one burst
    localparam logic [CNT_W-1:0] BURST_NONE = 3'd0;
    localparam logic [CNT_W-1:0] BURST_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] BURST_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] BURST_FOUR = 3'd4;

    // decoded mode bits handed to the pixel stage
    typedef struct packed {
        logic two_bit;
        logic mask_en;
        logic pair;
    } t_cfg;

    // bytes caused by one pixel, slot 0 goes out first
    typedef struct packed {
        logic [BURST_N-1:0][BYTE_W-1:0] bytes;
        logic [BURST_N-1:0]             is_mask;
        logic [CNT_W-1:0]               count;
        logic                           row_done;
    } t_burst;

    // width of the effective row width, wide enough for the register and the clamp
    function automatic int eff_w(input int max_width);
        int cw;
        cw = $clog2(max_width + 1);
        return (cw > ROW_W) ? cw : ROW_W;
    endfunction

endpackage

`default_nettype wire

FILE: sv/rtpp_core.sv
// pixel stage: input register, colour coding, row and byte accumulators
// depends on rtpp_pkg
`default_nettype none

module rtpp_core import rtpp_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_restart,
    input  wire t_cfg                         i_cfg,
    input  wire logic [eff_w(MAX_WIDTH)-1:0]  i_eff_width,
    input  wire logic                         i_in_valid,
    input  wire logic [PIX_W-1:0]             i_pixel_rgb,
    output logic                              o_in_ready,
    input  wire logic                         i_free,
    output logic                              o_load,
    output t_burst                            o_burst
);

    localparam int EW = eff_w(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH);

    localparam logic [PIX_W-1:0] RGB_BLACK   = 24'h000000;
    localparam logic [PIX_W-1:0] RGB_BLUE    = 24'h0000FF;
    localparam logic [PIX_W-1:0] RGB_GREEN   = 24'h00FF00;
    localparam logic [PIX_W-1:0] RGB_MAGENTA = 24'hFF00FF;

    logic               r_in_valid;
    logic [PIX_W-1:0]   r_pixel;
    logic [CW-1:0]      r_column;
    logic [ACC_W-1:0]   r_data;
    logic [ACC_W-1:0]   r_mask;

    logic [EW-1:0]      col_x;
    logic [2:0]         pos_lo;
    logic               half;
    logic               full;
    logic               rowend;
    logic [SHIFT_W-1:0] shift;
    logic [1:0]         code;
    logic [1:0]         ones;
    logic               transparent;
    logic [ACC_W-1:0]   data_new;
    logic [ACC_W-1:0]   mask_new;
    logic               clear_acc;
    logic               commit;
    t_burst             burst;

    // colour code of one pixel
    function automatic logic [1:0] colour_code(input logic [PIX_W-1:0] rgb,
                                               input logic two_bit);
        logic [1:0] c;
        if (!two_bit) begin
            c = (rgb == RGB_BLACK) ? 2'd0 : 2'd1;
        end else if (rgb == RGB_BLACK) begin
            c = 2'd0;
        end else if (rgb == RGB_BLUE) begin
            c = 2'd1;
        end else if (rgb == RGB_GREEN) begin
            c = 2'd2;
        end else begin
            c = 2'd3;
        end
        return c;
    endfunction

    // position of the pixel within its byte and pair
    assign col_x  = EW'(r_column);
    assign pos_lo = i_cfg.two_bit ? {col_x[1:0], 1'b0} : col_x[2:0];
    assign half   = i_cfg.two_bit ? col_x[2] : col_x[3];
    assign full   = i_cfg.two_bit ? (col_x[1:0] == 2'b11) : (col_x[2:0] == 3'b111);
    assign rowend = (col_x + EW'(1)) >= i_eff_width;
    assign shift  = {i_cfg.pair & half, pos_lo};

    // merge the pixel into the accumulators
    assign code        = colour_code(r_pixel, i_cfg.two_bit);
    assign ones        = i_cfg.two_bit ? 2'b11 : 2'b01;
    assign transparent = i_cfg.mask_en && (r_pixel == RGB_MAGENTA);
    assign data_new    = transparent ? r_data : (r_data | (ACC_W'(code) << shift));
    assign mask_new    = transparent ? r_mask : (r_mask | (ACC_W'(ones) << shift));

    // bytes completed by this pixel
    always_comb begin
        burst = '0;
        if (!i_cfg.mask_en) begin
            if (full || rowend) begin
                burst.count    = BURST_ONE;
                burst.bytes[0] = data_new[7:0];
            end
        end else if (!i_cfg.pair) begin
            if (full || rowend) begin
                burst.count      = BURST_TWO;
                burst.bytes[0]   = mask_new[7:0];
                burst.is_mask[0] = 1'b1;
                burst.bytes[1]   = data_new[7:0];
            end
        end else if ((full && half) || rowend) begin
            if (half) begin
                burst.count      = BURST_FOUR;
                burst.bytes[0]   = mask_new[7:0];
                burst.bytes[1]   = mask_new[15:8];
                burst.bytes[2]   = data_new[7:0];
                burst.bytes[3]   = data_new[15:8];
                burst.is_mask[0] = 1'b1;
                burst.is_mask[1] = 1'b1;
            end else begin
                // odd final pair: low byte alone
                burst.count      = BURST_TWO;
                burst.bytes[0]   = mask_new[7:0];
                burst.is_mask[0] = 1'b1;
                burst.bytes[1]   = data_new[7:0];
            end
        end
        burst.row_done = rowend;
    end

    // handshake: a pixel with bytes waits until the output buffer frees up
    assign clear_acc  = (burst.count != BURST_NONE) && (!i_cfg.pair || half || rowend);
    assign commit     = r_in_valid && ((burst.count == BURST_NONE) || i_free);
    assign o_in_ready = !r_in_valid || commit;
    assign o_load     = commit && (burst.count != BURST_NONE);
    assign o_burst    = burst;

    // control and row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_column   <= '0;
            r_data     <= '0;
            r_mask     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_restart) begin
                r_column <= '0;
                r_data   <= '0;
                r_mask   <= '0;
            end else if (commit) begin
                if (rowend || clear_acc) begin
                    r_data <= '0;
                    r_mask <= '0;
                end else begin
                    r_data <= data_new;
                    r_mask <= mask_new;
                end
                r_column <= rowend ? '0 : (r_column + CW'(1));
            end
        end
    end

    // pixel payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_pixel <= i_pixel_rgb;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rtpp_emit.sv
// output buffer: holds one burst of up to four bytes and hands them out in order
// depends on rtpp_pkg and the assertion macro header
`default_nettype none
`include "rgb_to_packed_pixels_with_mask_assert.svh"

module rtpp_emit import rtpp_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire t_burst        i_burst,
    output logic               o_free,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_is_mask_byte,
    output logic               o_row_done,
    output logic               o_run_last
);

    logic [CNT_W-1:0]               r_left;
    logic [BURST_N-1:0][BYTE_W-1:0] r_bytes;
    logic [BURST_N-1:0]             r_is_mask;
    logic                           r_row_done;
    logic                           take;

    // output request and buffer status
    assign o_out_valid    = (r_left != BURST_NONE);
    assign take           = o_out_valid && i_out_ready;
    assign o_free         = (r_left == BURST_NONE) || ((r_left == BURST_ONE) && take);
    assign o_out_byte     = r_bytes[0];
    assign o_is_mask_byte = r_is_mask[0];
    assign o_run_last     = (r_left == BURST_ONE);
    assign o_row_done     = r_row_done && (r_left == BURST_ONE);

    // bytes left in the burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= BURST_NONE;
        end else if (i_load) begin
            r_left <= i_burst.count;
        end else if (take) begin
            r_left <= r_left - BURST_ONE;
        end
    end

    // burst payload, shifted down one byte per request taken
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes    <= i_burst.bytes;
            r_is_mask  <= i_burst.is_mask;
            r_row_done <= i_burst.row_done;
        end else if (take) begin
            r_bytes   <= r_bytes >> BYTE_W;
            r_is_mask <= r_is_mask >> 1;
        end
    end

    `RTPP_ASSERT_NOW(a_load_when_free, i_load, o_free, "burst loaded over bytes still pending")
    `RTPP_ASSERT_NOW(a_load_count, i_load, (i_burst.count == BURST_ONE) || (i_burst.count == BURST_TWO) || (i_burst.count == BURST_FOUR), "burst of illegal length")
    `RTPP_ASSERT_NOW(a_row_done_last, o_out_valid && o_row_done, o_run_last, "row end flagged before last byte of burst")
    `RTPP_ASSERT_NEXT(a_drain_empty, take && (r_left == BURST_ONE) && !i_load, !o_out_valid, "buffer still valid after last byte taken")

endmodule

`default_nettype wire

FILE: sv/rgb_to_packed_pixels_with_mask.sv
// top level of the packed pixel converter: configuration registers and the two stages
// depends on rtpp_pkg, rtpp_core and rtpp_emit
//
//  channel   direction  handshake                   payload
//  pixel     in         i_in_valid / o_in_ready     i_pixel_rgb
//  bytes     out        o_out_valid / i_out_ready   o_out_byte, o_is_mask_byte,
//                                                   o_row_done, o_run_last
//  config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_wdata
//
// one pixel per cycle while no pixel waits; a pixel is held in the input register and
// its bytes pass through the output buffer, one byte per cycle while the sink is ready.
// the four-byte output buffer sets the rate: a pixel that completes bytes waits in the
// input register until the buffer is empty or its last byte goes; others pass freely.
// synchronous active-low reset; any configuration write restarts the current row.
`default_nettype none

module rgb_to_packed_pixels_with_mask import rtpp_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [PIX_W-1:0]      i_pixel_rgb,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [BYTE_W-1:0]          o_out_byte,
    output logic                       o_is_mask_byte,
    output logic                       o_row_done,
    output logic                       o_run_last,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ROW_W-1:0]      i_cfg_wdata
);

    localparam int EW = eff_w(MAX_WIDTH);

    logic [ROW_W-1:0] r_row_width;
    logic             r_two_bit;
    logic             r_mask_en;

    logic [EW-1:0]    rw_x;
    logic [EW-1:0]    eff_width;
    t_cfg             cfg;
    logic             free;
    logic             load;
    t_burst           burst;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_two_bit   <= 1'b1;
            r_mask_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_WIDTH: r_row_width <= i_cfg_wdata;
                CFG_TWO_BIT:   r_two_bit   <= i_cfg_wdata[0];
                CFG_MASK_EN:   r_mask_en   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // effective row width: zero counts as one, clamp to the largest row
    always_comb begin
        rw_x = EW'(r_row_width);
        if (rw_x == '0) begin
            eff_width = EW'(1);
        end else if (rw_x > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end else begin
            eff_width = rw_x;
        end
    end

    // decoded mode
    assign cfg = '{two_bit: r_two_bit,
                   mask_en: r_mask_en,
                   pair:    r_mask_en && (eff_width >= EW'(PAIR_MIN_WIDTH))};

    rtpp_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (i_cfg_we),
        .i_cfg       (cfg),
        .i_eff_width (eff_width),
        .i_in_valid  (i_in_valid),
        .i_pixel_rgb (i_pixel_rgb),
        .o_in_ready  (o_in_ready),
        .i_free      (free),
        .o_load      (load),
        .o_burst     (burst)
    );

    rtpp_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_burst        (burst),
        .o_free         (free),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_is_mask_byte (o_is_mask_byte),
        .o_row_done     (o_row_done),
        .o_run_last     (o_run_last)
    );

endmodule

`default_nettype wire
